// File: rtl/core/boundary_tag_first_fit_allocator_assert.svh
// ============================================================================
// Boundary tag allocator assertion macros
// Concurrent assertion wrappers used by the allocator walker RTL.
// ============================================================================
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BTA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BTA_ASSERT(label, clk, rst_n, prop, msg)
`define BTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/core/bta_pkg.sv
// ============================================================================
// Boundary tag allocator package
// Shared types, constants and helpers of the allocator.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
package bta_pkg;

    localparam int ARENA_BYTES_DEF = 131072;
    localparam int TAG_BYTES_DEF   = 16;
    localparam int WORD_W          = 22;
    localparam int TAG_W           = 22;
    localparam int FREE_POS        = 21;

    localparam logic [17:0] ARENA_RESET  = 18'd102400;
    localparam logic [10:0] MINREM_RESET = 11'd16;

    localparam logic CFG_ARENA  = 1'b0;
    localparam logic CFG_MINREM = 1'b1;
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [TAG_W-1:0]  t_tag;

    typedef enum logic [4:0] {
        S_FMT_H, S_FMT_T, S_IDLE,
        S_A_EV, S_A_W1, S_A_W2, S_A_W3, S_A_W4,
        S_F_EV, S_F_MK, S_F_MKT,
        S_P_CHK, S_P_EV, S_P_W1, S_P_W2,
        S_N_CHK, S_N_EV, S_N_W1, S_N_W2,
        S_RESP
    } t_state;

    typedef struct packed {
        logic  we;
        t_word waddr;
        t_tag  wdata;
        t_word raddr;
    } t_mem_req;

    typedef struct packed {
        logic  ok;
        t_word off;
    } t_result;

    function automatic t_tag mk_tag(input logic is_free, input t_word size);
        mk_tag = {is_free, size[FREE_POS-1:0]};
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/bta_ram.sv
// ============================================================================
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module bta_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/bta_walker.sv
// ============================================================================
// Boundary tag walker
// Sequencer that formats the arena and walks the tag chain for requests.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "boundary_tag_first_fit_allocator_assert.svh"
module bta_walker
    import bta_pkg::*;
#(
    parameter int TAG_BYTES = TAG_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fmt,
    input  wire t_word       i_span,
    input  wire logic [10:0] i_minrem,
    input  wire logic        i_start,
    input  wire logic        i_mode,
    input  wire logic [17:0] i_req,
    input  wire logic [16:0] i_uoff,
    input  wire logic        i_null,
    output logic             o_idle,
    output t_mem_req         o_mem,
    input  wire t_tag        i_rdata,
    input  wire logic        i_res_ready,
    output logic             o_res_valid,
    output t_result          o_res
);
    localparam t_word TB   = t_word'(TAG_BYTES);
    localparam t_word TB2  = t_word'(2 * TAG_BYTES);
    localparam t_word MASK = ~(t_word'(TAG_BYTES) - t_word'(1));

    t_state r_state, n_state;
    t_word  r_h, n_h, r_t, n_t, r_s, n_s, r_ns, n_ns, r_r, n_r, r_target, n_target;
    logic   r_split, n_split;
    t_result r_res, n_res;

    logic  e_free;
    t_word e_size, h_next, rnd, uoff_w, all_w, pt, ps_end;
    logic  a_fit, a_end, f_hit, f_end, too_small, bad_off, p_stop, n_end;

    assign e_free    = i_rdata[FREE_POS];
    assign e_size    = {1'b0, i_rdata[FREE_POS-1:0]};
    assign h_next    = r_h + TB2 + e_size;
    assign rnd       = (t_word'(i_req) + TB - t_word'(1)) & MASK;
    assign uoff_w    = t_word'(i_uoff);
    assign all_w     = r_r + TB2;
    assign too_small = i_span < TB2;
    assign bad_off   = too_small || uoff_w < TB || (uoff_w & ~MASK) != '0;
    assign a_end     = r_h >= i_span;
    assign a_fit     = e_free && e_size >= r_r;
    assign f_end     = r_h >= i_span;
    assign f_hit     = r_h == r_target;
    assign pt        = r_h - TB;
    assign ps_end    = e_size + TB;
    assign p_stop    = !e_free || ps_end > pt;
    assign n_end     = r_t + TB >= i_span;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FMT_H: n_state = S_FMT_T;
            S_FMT_T: n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_ALLOC) begin
                        n_state = too_small ? S_RESP : S_A_EV;
                    end else begin
                        n_state = (i_null || bad_off) ? S_RESP : S_F_EV;
                    end
                end
            end
            S_A_EV: begin
                if (a_end) begin
                    n_state = S_RESP;
                end else if (a_fit) begin
                    n_state = S_A_W1;
                end
            end
            S_A_W1: n_state = S_A_W2;
            S_A_W2: n_state = r_split ? S_A_W3 : S_RESP;
            S_A_W3: n_state = S_A_W4;
            S_A_W4: n_state = S_RESP;
            S_F_EV: begin
                if (f_end) begin
                    n_state = S_RESP;
                end else if (f_hit) begin
                    n_state = e_free ? S_RESP : S_F_MK;
                end
            end
            S_F_MK:  n_state = S_F_MKT;
            S_F_MKT: n_state = S_P_CHK;
            S_P_CHK: n_state = (r_h == '0) ? S_N_CHK : S_P_EV;
            S_P_EV:  n_state = p_stop ? S_N_CHK : S_P_W1;
            S_P_W1:  n_state = S_P_W2;
            S_P_W2:  n_state = S_P_CHK;
            S_N_CHK: n_state = n_end ? S_RESP : S_N_EV;
            S_N_EV:  n_state = e_free ? S_N_W1 : S_RESP;
            S_N_W1:  n_state = S_N_W2;
            S_N_W2:  n_state = S_N_CHK;
            S_RESP:  n_state = i_res_ready ? S_IDLE : S_RESP;
            default: n_state = S_FMT_H;
        endcase
        if (i_fmt) begin
            n_state = S_FMT_H;
        end
    end

    always_comb begin
        n_h      = r_h;
        n_t      = r_t;
        n_s      = r_s;
        n_ns     = r_ns;
        n_r      = r_r;
        n_target = r_target;
        n_split  = r_split;
        n_res    = r_res;
        o_mem    = '0;
        unique case (r_state)
            S_FMT_H: begin
                o_mem.we    = !too_small;
                o_mem.waddr = '0;
                o_mem.wdata = mk_tag(1'b1, i_span - TB2);
            end
            S_FMT_T: begin
                o_mem.we    = !too_small;
                o_mem.waddr = i_span - TB;
                o_mem.wdata = mk_tag(1'b1, i_span - TB2);
            end
            S_IDLE: begin
                n_h      = '0;
                n_r      = rnd;
                n_target = uoff_w - TB;
                n_res.ok = (i_mode == MODE_FREE) && i_null;
                n_res.off = '0;
            end
            S_A_EV: begin
                if (!a_end && a_fit) begin
                    n_s     = e_size;
                    n_t     = r_h + TB + e_size;
                    n_ns    = e_size - all_w;
                    n_split = !(e_size <= all_w ||
                                (e_size - all_w) < t_word'(i_minrem));
                end else begin
                    n_h         = h_next;
                    o_mem.raddr = h_next;
                end
            end
            S_A_W1: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_h;
                o_mem.wdata = r_split ? mk_tag(1'b1, r_ns) : mk_tag(1'b0, r_s);
                n_res.ok    = 1'b1;
                n_res.off   = r_h + TB;
            end
            S_A_W2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_split ? (r_h + TB + r_ns) : r_t;
                o_mem.wdata = r_split ? mk_tag(1'b1, r_ns) : mk_tag(1'b0, r_s);
                n_h         = r_h + TB2 + r_ns;
            end
            S_A_W3: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_h;
                o_mem.wdata = mk_tag(1'b0, r_r);
                n_res.off   = r_h + TB;
            end
            S_A_W4: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_t;
                o_mem.wdata = mk_tag(1'b0, r_r);
            end
            S_F_EV: begin
                if (!f_end && f_hit) begin
                    n_s = e_size;
                    n_t = r_h + TB + e_size;
                end else begin
                    n_h         = h_next;
                    o_mem.raddr = h_next;
                end
            end
            S_F_MK: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_h;
                o_mem.wdata = mk_tag(1'b1, r_s);
                n_res.ok    = 1'b1;
            end
            S_F_MKT: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_t;
                o_mem.wdata = mk_tag(1'b1, r_s);
            end
            S_P_CHK: begin
                o_mem.raddr = pt;
            end
            S_P_EV: begin
                if (!p_stop) begin
                    n_h = pt - ps_end;
                end
            end
            S_P_W1, S_N_W1: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_h;
                o_mem.wdata = mk_tag(1'b1, r_t - r_h - TB);
            end
            S_P_W2, S_N_W2: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_t;
                o_mem.wdata = mk_tag(1'b1, r_t - r_h - TB);
            end
            S_N_CHK: begin
                o_mem.raddr = r_t + TB;
            end
            S_N_EV: begin
                if (e_free) begin
                    n_t = r_t + TB2 + e_size;
                end
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FMT_H;
        end else begin
            r_state <= n_state;
        end
        r_h      <= n_h;
        r_t      <= n_t;
        r_s      <= n_s;
        r_ns     <= n_ns;
        r_r      <= n_r;
        r_target <= n_target;
        r_split  <= n_split;
        r_res    <= n_res;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESP);
    assign o_res       = r_res;

    `BTA_ASSERT(a_wr_in_arena, i_clk, i_rst_n, !o_mem.we || o_mem.waddr < i_span, "tag write beyond arena")
    `BTA_ASSERT(a_fail_zero, i_clk, i_rst_n, !o_res_valid || o_res.ok || o_res.off == '0, "failed result with offset")
    `BTA_ASSERT_NEXT(a_null_free, i_clk, i_rst_n, o_idle && i_start && i_mode == MODE_FREE && i_null && !i_fmt, r_state == S_RESP && r_res.ok, "null free not answered at once")
endmodule
`default_nettype wire

// File: rtl/core/boundary_tag_first_fit_allocator.sv
// ============================================================================
// Boundary tag first-fit allocator
// Arena allocator with header and tail tags, first-fit search and coalescing.
// ============================================================================
//  Channel   Direction  Content
//  s_axis    in         request: tuser mode/null flag, tdata size and offset
//  m_axis    out        response: tuser success, tdata data offset
//  cfg       in         register writes: arena size, minimum remainder
//
//  An allocate walks the blocks to the first fit, makes up to four tag writes and responds.
//  A free walks the blocks up to its target, writes its two tags, rewrites the merged block's
//  tags for each free neighbour, checks the neighbours on both sides, then responds.
//  After reset or an arena size write, S_FMT_H and S_FMT_T format the arena; no request is taken meanwhile.
//  A finished response waits in an output register, so a stall on m_axis stalls only the next.
`timescale 1ns / 1ps
`default_nettype none
module boundary_tag_first_fit_allocator
    import bta_pkg::*;
#(
    parameter int ARENA_BYTES = ARENA_BYTES_DEF,
    parameter int TAG_BYTES   = TAG_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // request_size, user_offset
    input  wire logic [1:0]  s_axis_tuser,  // mode, null_pointer
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // data_offset
    output logic [0:0]       m_axis_tuser,  // success
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [17:0] i_cfg_data
);
    localparam int GRAN   = ARENA_BYTES / TAG_BYTES;
    localparam int GW     = $clog2(GRAN);
    localparam int TAG_SH = $clog2(TAG_BYTES);
    localparam t_word ARENA_W = t_word'(ARENA_BYTES);
    localparam t_word MASK    = ~(t_word'(TAG_BYTES) - t_word'(1));

    logic [17:0] r_arena;
    logic [10:0] r_minrem;
    logic        r_out_valid, r_out_ok;
    logic [16:0] r_out_off;
    t_word       arena_w, span;
    logic        fmt, start, idle, res_valid, res_ready;
    t_mem_req    mem;
    t_tag        rdata;
    t_result     res;

    assign arena_w = t_word'(r_arena);
    assign span    = ((arena_w < ARENA_W) ? arena_w : ARENA_W) & MASK;
    assign fmt     = i_cfg_we && i_cfg_index == CFG_ARENA;
    assign start   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = idle;
    assign res_ready     = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena     <= ARENA_RESET;
            r_minrem    <= MINREM_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ARENA) begin
                    r_arena <= i_cfg_data;
                end else begin
                    r_minrem <= i_cfg_data[10:0];
                end
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_valid && res_ready) begin
            r_out_ok  <= res.ok;
            r_out_off <= res.off[16:0];
        end
    end

    bta_walker #(
        .TAG_BYTES (TAG_BYTES)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fmt       (fmt),
        .i_span      (span),
        .i_minrem    (r_minrem),
        .i_start     (start),
        .i_mode      (s_axis_tuser[0]),
        .i_req       (s_axis_tdata[17:0]),
        .i_uoff      (s_axis_tdata[34:18]),
        .i_null      (s_axis_tuser[1]),
        .o_idle      (idle),
        .o_mem       (mem),
        .i_rdata     (rdata),
        .i_res_ready (res_ready),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    bta_ram #(
        .WIDTH (TAG_W),
        .DEPTH (GRAN)
    ) u_tags (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr[TAG_SH +: GW]),
        .i_wdata (mem.wdata),
        .i_raddr (mem.raddr[TAG_SH +: GW]),
        .o_rdata (rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_off};
    assign m_axis_tuser  = r_out_ok;
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// ============================================================================
// Boundary tag allocator testbench
// Drives allocate and free requests into the allocator under several arena
// and remainder settings, predicts every response with an internal tag-store
// model and compares each response field by field with the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import bta_pkg::*;

    localparam int          ARENA_MAX   = 131072;
    localparam int          GRAIN       = 16;
    localparam int          GRAINS      = ARENA_MAX / GRAIN;
    localparam int unsigned FREE_FLAG   = 32'h0020_0000;
    localparam int unsigned SIZE_BITS   = 32'h001F_FFFF;
    localparam int          CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        ok;
        logic [16:0] offset;
    } response_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_ARENA;
    logic [17:0] i_cfg_data = '0;

    boundary_tag_first_fit_allocator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Predicted allocator state.
    logic [21:0]  tags [GRAINS];
    int unsigned  arena_reg;
    int unsigned  min_rem;
    int unsigned  span;

    response_t    pending_responses [$];
    int unsigned  live_offsets [$];
    int           errors = 0;
    int unsigned  cycle_count = 0;
    int           burst_left = 0;
    bit           sender_gaps = 1'b1;
    bit           receiver_stalls = 1'b1;
    logic [15:0]  stall_pattern = 16'hA5C3;

    function automatic int unsigned tag_read(int unsigned off);
        int unsigned idx;
        idx = off / GRAIN;
        return (idx < GRAINS) ? int'(tags[idx]) : 0;
    endfunction

    function automatic void tag_write(int unsigned off, bit is_free, int unsigned size);
        int unsigned idx;
        idx = off / GRAIN;
        if (idx < GRAINS)
            tags[idx] = {is_free, size[20:0]};
    endfunction

    function automatic void format_arena();
        int unsigned a;
        a = (arena_reg < ARENA_MAX) ? arena_reg : ARENA_MAX;
        foreach (tags[i])
            tags[i] = '0;
        span = a / GRAIN * GRAIN;
        if (span >= 2 * GRAIN) begin
            tag_write(0, 1'b1, span - 2 * GRAIN);
            tag_write(span - GRAIN, 1'b1, span - 2 * GRAIN);
        end
    endfunction

    function automatic int unsigned next_block(int unsigned h);
        return h + 2 * GRAIN + (tag_read(h) & SIZE_BITS);
    endfunction

    function automatic response_t predict_allocate(int unsigned req);
        response_t   r;
        int unsigned want, h, e, s, whole, tail, rest, nh;
        r = '0;
        want = (req + GRAIN - 1) / GRAIN * GRAIN;
        h = 0;
        if (span < 2 * GRAIN)
            return r;
        while (h < span) begin
            e = tag_read(h);
            s = e & SIZE_BITS;
            if ((e & FREE_FLAG) != 0 && s >= want) begin
                whole = want + 2 * GRAIN;
                tail = h + GRAIN + s;
                r.ok = 1'b1;
                if (s <= whole || s - whole < min_rem) begin
                    tag_write(h, 1'b0, s);
                    tag_write(tail, 1'b0, s);
                    r.offset = 17'(h + GRAIN);
                end else begin
                    rest = s - whole;
                    nh = h + 2 * GRAIN + rest;
                    tag_write(h, 1'b1, rest);
                    tag_write(h + GRAIN + rest, 1'b1, rest);
                    tag_write(nh, 1'b0, want);
                    tag_write(tail, 1'b0, want);
                    r.offset = 17'(nh + GRAIN);
                end
                return r;
            end
            h = next_block(h);
        end
        return r;
    endfunction

    function automatic bit predict_release(int unsigned off);
        int unsigned target, h, e, t, n, pt, pe, ps, ph;
        if (span < 2 * GRAIN || off < GRAIN || off % GRAIN != 0)
            return 1'b0;
        target = off - GRAIN;
        h = 0;
        while (h < span && h != target)
            h = next_block(h);
        if (h != target || h >= span)
            return 1'b0;
        e = tag_read(h);
        if ((e & FREE_FLAG) != 0)
            return 1'b0;
        t = h + GRAIN + (e & SIZE_BITS);
        tag_write(h, 1'b1, e & SIZE_BITS);
        tag_write(t, 1'b1, e & SIZE_BITS);
        while (h != 0) begin
            pt = h - GRAIN;
            pe = tag_read(pt);
            ps = pe & SIZE_BITS;
            if ((pe & FREE_FLAG) == 0 || ps + GRAIN > pt)
                break;
            ph = pt - GRAIN - ps;
            tag_write(ph, 1'b1, t - ph - GRAIN);
            tag_write(t, 1'b1, t - ph - GRAIN);
            h = ph;
        end
        forever begin
            n = t + GRAIN;
            if (n >= span)
                break;
            e = tag_read(n);
            if ((e & FREE_FLAG) == 0)
                break;
            t = n + GRAIN + (e & SIZE_BITS);
            tag_write(h, 1'b1, t - h - GRAIN);
            tag_write(t, 1'b1, t - h - GRAIN);
        end
        return 1'b1;
    endfunction

    // Sends one request and records the predicted response once it is accepted.
    task automatic send_request(logic mode, int unsigned req, int unsigned uoff, logic is_null);
        response_t r;
        if (sender_gaps && burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        burst_left = burst_left - 1;
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {5'b0, uoff[16:0], req[17:0]};
        s_axis_tuser = {is_null, mode};
        do @(posedge i_clk); while (!s_axis_tready);
        r = '0;
        if (mode == MODE_ALLOC) begin
            r = predict_allocate(req[17:0]);
            if (r.ok)
                live_offsets.push_back(r.offset);
        end else if (is_null) begin
            r.ok = 1'b1;
        end else begin
            r.ok = predict_release(uoff[16:0]);
        end
        pending_responses.push_back(r);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_responses.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_register(logic index, int unsigned value);
        wait_idle();
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value[17:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == CFG_ARENA) begin
            arena_reg = value[17:0];
            format_arena();
            live_offsets.delete();
        end else begin
            min_rem = value[10:0];
        end
    endtask

    task automatic allocate(int unsigned req);
        send_request(MODE_ALLOC, req, $urandom_range(0, 131071), 1'b0);
    endtask

    task automatic release_block(int unsigned off);
        send_request(MODE_FREE, $urandom_range(0, 262143), off, 1'b0);
    endtask

    task automatic test_directed();
        int unsigned a, b, c;
        allocate(0);
        allocate(1);
        allocate(100);
        allocate(262143);
        allocate(131072);
        send_request(MODE_FREE, 0, 17'h1FFFF, 1'b1);
        release_block(0);
        release_block(17);
        release_block(131071);
        a = live_offsets[0];
        release_block(a);
        release_block(a);
        live_offsets.delete();
        write_register(CFG_ARENA, 1024);
        allocate(64);
        allocate(64);
        allocate(64);
        a = live_offsets[0];
        b = live_offsets[1];
        c = live_offsets[2];
        release_block(a);
        release_block(c);
        release_block(b);
        allocate(1024 - 32);
        allocate(1024 - 64);
        live_offsets.delete();
    endtask

    task automatic test_arena_limits();
        write_register(CFG_ARENA, 20);
        allocate(0);
        release_block(16);
        send_request(MODE_FREE, 0, 0, 1'b1);
        write_register(CFG_ARENA, 262143);
        allocate(ARENA_MAX - 32);
        release_block(16);
        write_register(CFG_ARENA, 1030);
        allocate(900);
        allocate(0);
    endtask

    task automatic test_random(int unsigned arena, int unsigned rem, int count);
        int unsigned pick, idx, sz;
        write_register(CFG_ARENA, arena);
        write_register(CFG_MINREM, rem);
        sender_gaps = $urandom_range(0, 3) != 0;
        receiver_stalls = $urandom_range(0, 3) != 0;
        stall_pattern = $urandom();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 && live_offsets.size() != 0) begin
                idx = $urandom_range(0, live_offsets.size() - 1);
                release_block(live_offsets[idx]);
                live_offsets.delete(idx);
            end else if (pick < 48) begin
                case ($urandom_range(0, 2))
                    0: send_request(MODE_FREE, $urandom(), $urandom(), 1'b1);
                    1: release_block($urandom_range(0, 131071));
                    default: release_block($urandom_range(1, 200) * GRAIN);
                endcase
            end else begin
                sz = $urandom_range(0, 99);
                if (sz < 80)
                    allocate($urandom_range(0, 600));
                else if (sz < 96)
                    allocate($urandom_range(0, 8000));
                else
                    allocate($urandom_range(0, 262143));
            end
        end
    endtask

    // Response checker.
    always @(posedge i_clk) begin
        response_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected response ok=%0d offset=%0d", $realtime,
                         m_axis_tuser[0], m_axis_tdata[16:0]);
                errors++;
            end else begin
                want = pending_responses.pop_front();
                if (m_axis_tuser[0] !== want.ok) begin
                    $display("%0t: success expected %0d actual %0d", $realtime,
                             want.ok, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata !== {7'b0, want.offset}) begin
                    $display("%0t: data_offset expected %0d actual %0d", $realtime,
                             want.offset, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !receiver_stalls || stall_pattern[cycle_count % 16] ||
                         $urandom_range(0, 3) == 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        arena_reg = ARENA_RESET;
        min_rem = MINREM_RESET;
        format_arena();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_arena_limits();
        test_random(ARENA_RESET, MINREM_RESET, 130);
        test_random(1024, 0, 120);
        test_random(131072, 1024, 130);
        test_random(5000, 48, 120);
        test_random(262143, 2047, 130);
        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
